// ===== sv/glx_pkg.sv =====
// ----------------------------------------------------------------------------
// glx_pkg: shared types and constants of the graph-language lexer
// Token kind codes, the keyword table and the result burst handed from the
// scanner to the output stage.
// ----------------------------------------------------------------------------
package glx_pkg;

   localparam int HOLD_LIMIT = 8;   // longest keyword
   localparam int HOLD_IDX_W = 3;   // index bits for HOLD_LIMIT entries
   localparam int KW_COUNT   = 6;

   localparam logic [4:0] KIND_END        = 5'd0;
   localparam logic [4:0] KIND_ERROR      = 5'd1;
   localparam logic [4:0] KIND_KW_BASE    = 5'd2;
   localparam logic [4:0] KIND_LBRACE     = 5'd8;
   localparam logic [4:0] KIND_RBRACE     = 5'd9;
   localparam logic [4:0] KIND_SEMI       = 5'd10;
   localparam logic [4:0] KIND_EQUAL      = 5'd11;
   localparam logic [4:0] KIND_LBRACKET   = 5'd12;
   localparam logic [4:0] KIND_RBRACKET   = 5'd13;
   localparam logic [4:0] KIND_COMMA      = 5'd14;
   localparam logic [4:0] KIND_COLON      = 5'd15;
   localparam logic [4:0] KIND_LPAREN     = 5'd16;
   localparam logic [4:0] KIND_RPAREN     = 5'd17;
   localparam logic [4:0] KIND_AT         = 5'd18;
   localparam logic [4:0] KIND_ARROW      = 5'd19;
   localparam logic [4:0] KIND_MINUSMINUS = 5'd20;
   localparam logic [4:0] KIND_VALUE      = 5'd21;
   localparam logic [4:0] KIND_IDEND      = 5'd22;

   typedef logic [HOLD_LIMIT-1:0][7:0] held_type;

   localparam logic [7:0] KW_TEXT [KW_COUNT][HOLD_LIMIT] = '{
      '{"s", "t", "r", "i", "c", "t", 8'h00, 8'h00},
      '{"d", "i", "g", "r", "a", "p", "h", 8'h00},
      '{"g", "r", "a", "p", "h", 8'h00, 8'h00, 8'h00},
      '{"n", "o", "d", "e", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"e", "d", "g", "e", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"s", "u", "b", "g", "r", "a", "p", "h"}
   };
   localparam logic [3:0] KW_LEN [KW_COUNT] = '{4'd6, 4'd7, 4'd5, 4'd4, 4'd4, 4'd8};

   typedef struct packed {
      logic       hit;
      logic [4:0] kind;
   } kw_result_type;

   // All results of one request: held bytes first, then up to two tokens.
   typedef struct packed {
      logic [3:0] flush_cnt;
      held_type   flush_bytes;
      logic [1:0] tail_cnt;
      logic [4:0] tail0_kind;
      logic [7:0] tail0_value;
      logic [4:0] tail1_kind;
   } burst_type;

   function automatic kw_result_type kw_lookup(input held_type held, input logic [3:0] cnt);
      kw_result_type res;
      logic          same;
      res.hit  = 1'b0;
      res.kind = KIND_ERROR;
      for (int k = 0; k < KW_COUNT; k++) begin
         same = (cnt == KW_LEN[k]);
         for (int i = 0; i < HOLD_LIMIT; i++) begin
            if ((4'(i) < KW_LEN[k]) && (held[i] != KW_TEXT[k][i])) begin
               same = 1'b0;
            end
         end
         if (same) begin
            res.hit  = 1'b1;
            res.kind = KIND_KW_BASE + 5'(k);
         end
      end
      return res;
   endfunction

endpackage

// ===== sv/glx_if.sv =====
// ----------------------------------------------------------------------------
// glx_if: request and response channels of the graph-language lexer
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface glx_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       end_of_input;

   modport source (output valid, output byte_in, output end_of_input, input ready);
   modport sink   (input valid, input byte_in, input end_of_input, output ready);
endinterface

interface glx_rsp_if;
   logic       valid;
   logic       ready;
   logic [4:0] kind;
   logic [7:0] value_byte;
   logic       last_of_run;

   modport source (output valid, output kind, output value_byte, output last_of_run,
                   input ready);
   modport sink   (input valid, input kind, input value_byte, input last_of_run,
                   output ready);
endinterface

// ===== sv/glx_scan.sv =====
// ----------------------------------------------------------------------------
// glx_scan: scanner state and per-byte token decision
// Updates the scan mode and held identifier bytes for each accepted request
// and builds the burst of results that the request causes.
// ----------------------------------------------------------------------------
module glx_scan (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         byte_in,
   input  logic               end_of_input,
   output glx_pkg::burst_type burst
);

   typedef enum logic [3:0] {
      MODE_IDLE,
      MODE_SLASH,
      MODE_LINE,
      MODE_BLOCK,
      MODE_BLOCK_STAR,
      MODE_MINUS,
      MODE_STRING,
      MODE_ESCAPE,
      MODE_IDENT
   } mode_type;

   mode_type          mode_ff, mode_in;
   glx_pkg::held_type held_ff, held_in;
   logic [3:0]        cnt_ff, cnt_in;
   logic              long_ff, long_in;

   logic                   is_ident, is_space;
   mode_type               idle_mode;
   logic                   idle_tok_vld, idle_start;
   logic [4:0]             idle_tok_kind;
   glx_pkg::kw_result_type kw;

   assign is_ident = ((byte_in >= "a") && (byte_in <= "z")) ||
                     ((byte_in >= "A") && (byte_in <= "Z")) ||
                     ((byte_in >= "0") && (byte_in <= "9")) ||
                     (byte_in == "_") || (byte_in == ".");
   assign is_space = (byte_in == " ") || ((byte_in >= 8'h09) && (byte_in <= 8'h0D));

   assign kw = glx_pkg::kw_lookup(held_ff, cnt_ff);

   // What a byte does when it starts a new token.
   always_comb begin
      idle_mode     = MODE_IDLE;
      idle_tok_vld  = 1'b0;
      idle_tok_kind = glx_pkg::KIND_ERROR;
      idle_start    = 1'b0;
      case (byte_in)
         "/":  idle_mode = MODE_SLASH;
         "-":  idle_mode = MODE_MINUS;
         "\"": idle_mode = MODE_STRING;
         "{": begin idle_tok_vld = 1'b1; idle_tok_kind = glx_pkg::KIND_LBRACE;   end
         "}": begin idle_tok_vld = 1'b1; idle_tok_kind = glx_pkg::KIND_RBRACE;   end
         ";": begin idle_tok_vld = 1'b1; idle_tok_kind = glx_pkg::KIND_SEMI;     end
         "=": begin idle_tok_vld = 1'b1; idle_tok_kind = glx_pkg::KIND_EQUAL;    end
         "[": begin idle_tok_vld = 1'b1; idle_tok_kind = glx_pkg::KIND_LBRACKET; end
         "]": begin idle_tok_vld = 1'b1; idle_tok_kind = glx_pkg::KIND_RBRACKET; end
         ",": begin idle_tok_vld = 1'b1; idle_tok_kind = glx_pkg::KIND_COMMA;    end
         ":": begin idle_tok_vld = 1'b1; idle_tok_kind = glx_pkg::KIND_COLON;    end
         "(": begin idle_tok_vld = 1'b1; idle_tok_kind = glx_pkg::KIND_LPAREN;   end
         ")": begin idle_tok_vld = 1'b1; idle_tok_kind = glx_pkg::KIND_RPAREN;   end
         "@": begin idle_tok_vld = 1'b1; idle_tok_kind = glx_pkg::KIND_AT;       end
         default: begin
            if (is_space) begin
               idle_mode = MODE_IDLE;
            end else if (is_ident) begin
               idle_mode  = MODE_IDENT;
               idle_start = 1'b1;
            end else begin
               idle_tok_vld = 1'b1;
            end
         end
      endcase
   end

   always_comb begin
      mode_in = mode_ff;
      held_in = held_ff;
      cnt_in  = cnt_ff;
      long_in = long_ff;
      burst.flush_cnt   = 4'd0;
      burst.flush_bytes = held_ff;
      burst.tail_cnt    = 2'd0;
      burst.tail0_kind  = glx_pkg::KIND_ERROR;
      burst.tail0_value = 8'd0;
      burst.tail1_kind  = glx_pkg::KIND_END;
      if (accept) begin
         if (end_of_input) begin
            mode_in = MODE_IDLE;
            cnt_in  = 4'd0;
            long_in = 1'b0;
            case (mode_ff)
               MODE_IDLE: begin
                  burst.tail_cnt   = 2'd1;
                  burst.tail0_kind = glx_pkg::KIND_END;
               end
               MODE_IDENT: begin
                  burst.tail_cnt   = 2'd2;
                  burst.tail0_kind = (!long_ff && kw.hit) ? kw.kind : glx_pkg::KIND_IDEND;
                  burst.flush_cnt  = (!long_ff && !kw.hit) ? cnt_ff : 4'd0;
               end
               default: burst.tail_cnt = 2'd1;
            endcase
         end else begin
            case (mode_ff)
               MODE_IDENT: begin
                  if (is_ident) begin
                     if (long_ff) begin
                        burst.tail_cnt    = 2'd1;
                        burst.tail0_kind  = glx_pkg::KIND_VALUE;
                        burst.tail0_value = byte_in;
                     end else if (cnt_ff < 4'(glx_pkg::HOLD_LIMIT)) begin
                        held_in[cnt_ff[glx_pkg::HOLD_IDX_W-1:0]] = byte_in;
                        cnt_in = cnt_ff + 4'd1;
                     end else begin
                        // Hold is full: spill it and stream the rest of the run.
                        burst.flush_cnt   = cnt_ff;
                        burst.tail_cnt    = 2'd1;
                        burst.tail0_kind  = glx_pkg::KIND_VALUE;
                        burst.tail0_value = byte_in;
                        cnt_in  = 4'd0;
                        long_in = 1'b1;
                     end
                  end else begin
                     burst.tail0_kind = (!long_ff && kw.hit) ? kw.kind : glx_pkg::KIND_IDEND;
                     burst.flush_cnt  = (!long_ff && !kw.hit) ? cnt_ff : 4'd0;
                     burst.tail1_kind = idle_tok_kind;
                     burst.tail_cnt   = idle_tok_vld ? 2'd2 : 2'd1;
                     mode_in = idle_mode;
                     long_in = 1'b0;
                     cnt_in  = idle_start ? 4'd1 : 4'd0;
                     if (idle_start) begin
                        held_in[0] = byte_in;
                     end
                  end
               end
               MODE_SLASH: begin
                  if (byte_in == "/") begin
                     mode_in = MODE_LINE;
                  end else if (byte_in == "*") begin
                     mode_in = MODE_BLOCK;
                  end else begin
                     burst.tail_cnt = 2'd1;
                     mode_in = MODE_IDLE;
                  end
               end
               MODE_LINE: begin
                  if (byte_in == 8'h0A) begin
                     mode_in = MODE_IDLE;
                  end
               end
               MODE_BLOCK: begin
                  if (byte_in == "*") begin
                     mode_in = MODE_BLOCK_STAR;
                  end
               end
               MODE_BLOCK_STAR: begin
                  if (byte_in == "/") begin
                     mode_in = MODE_IDLE;
                  end else if (byte_in != "*") begin
                     mode_in = MODE_BLOCK;
                  end
               end
               MODE_MINUS: begin
                  burst.tail_cnt = 2'd1;
                  if (byte_in == ">") begin
                     burst.tail0_kind = glx_pkg::KIND_ARROW;
                  end else if (byte_in == "-") begin
                     burst.tail0_kind = glx_pkg::KIND_MINUSMINUS;
                  end
                  mode_in = MODE_IDLE;
               end
               MODE_STRING: begin
                  if (byte_in == "\"") begin
                     burst.tail_cnt   = 2'd1;
                     burst.tail0_kind = glx_pkg::KIND_IDEND;
                     mode_in = MODE_IDLE;
                  end else if (byte_in == "\\") begin
                     mode_in = MODE_ESCAPE;
                  end else begin
                     burst.tail_cnt    = 2'd1;
                     burst.tail0_kind  = glx_pkg::KIND_VALUE;
                     burst.tail0_value = byte_in;
                  end
               end
               MODE_ESCAPE: begin
                  burst.tail_cnt    = 2'd1;
                  burst.tail0_kind  = glx_pkg::KIND_VALUE;
                  burst.tail0_value = byte_in;
                  mode_in = MODE_STRING;
               end
               default: begin
                  mode_in          = idle_mode;
                  burst.tail_cnt   = idle_tok_vld ? 2'd1 : 2'd0;
                  burst.tail0_kind = idle_tok_kind;
                  if (idle_start) begin
                     held_in[0] = byte_in;
                     cnt_in     = 4'd1;
                     long_in    = 1'b0;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         cnt_ff  <= 4'd0;
         long_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         cnt_ff  <= cnt_in;
         long_ff <= long_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

   a_cnt_bounded: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 4'(glx_pkg::HOLD_LIMIT))
      else $error("held byte count exceeds hold depth");

   a_long_empty: assert property (@(posedge clock) disable iff (reset)
      long_ff |-> (cnt_ff == 4'd0))
      else $error("bytes held while streaming a long identifier");

   a_hold_only_in_ident: assert property (@(posedge clock) disable iff (reset)
      (mode_ff != MODE_IDENT) |-> ((cnt_ff == 4'd0) && !long_ff))
      else $error("identifier state left over outside an identifier");

endmodule

// ===== sv/glx_burst.sv =====
// ----------------------------------------------------------------------------
// glx_burst: result buffer and response drain
// Holds all results of one request and hands them out one per transfer,
// marking the final one.
// ----------------------------------------------------------------------------
module glx_burst (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  glx_pkg::burst_type burst,
   output logic               ready,
   glx_rsp_if.source          rsp_ch
);

   logic              busy_ff, busy_in;
   logic [3:0]        pos_ff, pos_in;
   logic [3:0]        total_ff;
   logic [3:0]        fl_cnt_ff;
   glx_pkg::held_type fl_ff;
   logic [4:0]        tail0_kind_ff;
   logic [7:0]        tail0_value_ff;
   logic [4:0]        tail1_kind_ff;
   logic [3:0]        load_total;
   logic              fire, last;

   assign load_total = burst.flush_cnt + 4'(burst.tail_cnt);
   assign last       = (pos_ff == (total_ff - 4'd1));
   assign fire       = rsp_ch.valid && rsp_ch.ready;
   assign ready      = !busy_ff || (fire && last);

   always_comb begin
      busy_in = busy_ff;
      pos_in  = pos_ff;
      if (fire) begin
         pos_in = pos_ff + 4'd1;
         if (last) begin
            busy_in = 1'b0;
         end
      end
      if (load) begin
         busy_in = (load_total != 4'd0);
         pos_in  = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff  <= 4'd0;
      end else begin
         busy_ff <= busy_in;
         pos_ff  <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         total_ff       <= load_total;
         fl_cnt_ff      <= burst.flush_cnt;
         fl_ff          <= burst.flush_bytes;
         tail0_kind_ff  <= burst.tail0_kind;
         tail0_value_ff <= burst.tail0_value;
         tail1_kind_ff  <= burst.tail1_kind;
      end
   end

   always_comb begin
      rsp_ch.valid       = busy_ff;
      rsp_ch.last_of_run = last;
      if (pos_ff < fl_cnt_ff) begin
         rsp_ch.kind       = glx_pkg::KIND_VALUE;
         rsp_ch.value_byte = fl_ff[pos_ff[glx_pkg::HOLD_IDX_W-1:0]];
      end else if (pos_ff == fl_cnt_ff) begin
         rsp_ch.kind       = tail0_kind_ff;
         rsp_ch.value_byte = tail0_value_ff;
      end else begin
         rsp_ch.kind       = tail1_kind_ff;
         rsp_ch.value_byte = 8'd0;
      end
   end

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (pos_ff < total_ff))
      else $error("response index beyond burst length");

   a_drain_ends: assert property (@(posedge clock) disable iff (reset)
      (fire && last && !load) |=> !busy_ff)
      else $error("response still valid after final result taken");

   a_load_starts: assert property (@(posedge clock) disable iff (reset)
      (load && (load_total != 4'd0)) |=> (busy_ff && (pos_ff == 4'd0)))
      else $error("burst not started at first result");

endmodule

// ===== sv/graph_language_lexer_core.sv =====
// ----------------------------------------------------------------------------
// graph_language_lexer_core: graph-language tokenizer
// One source byte per request in, tokens out on the response channel.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one source byte (byte_in) or an end_of_input marker per
//   request. rsp_ch carries token kind, value_byte for identifier and string
//   bytes, and last_of_run on the final response caused by a request.
//   A request may cause no response (whitespace, comments, held identifier
//   bytes) or up to ten (a spilled identifier plus its following tokens).
// Latency: the first response of a request is valid in the cycle after the
//   request is taken.
// Throughput: one request per cycle while each causes at most one response
//   and rsp_ch.ready is high. The rate is set by the single result buffer
//   that drains one response per cycle while rsp_ch.ready is high; the next
//   request is taken in the cycle its last one leaves.
// Reset: synchronous; the scanner returns to the between-tokens state and
//   any pending responses are dropped.
// Stall: while rsp_ch.ready is low the response holds and req_ch.ready
//   stays low until the buffered burst is drained.
// ----------------------------------------------------------------------------
module graph_language_lexer_core (
   input  logic      clock,
   input  logic      reset,
   glx_req_if.sink   req_ch,
   glx_rsp_if.source rsp_ch
);

   glx_pkg::burst_type burst;
   logic               ready;
   logic               accept;

   assign req_ch.ready = ready;
   assign accept       = req_ch.valid && ready;

   glx_scan u_scan (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .byte_in      (req_ch.byte_in),
      .end_of_input (req_ch.end_of_input),
      .burst        (burst)
   );

   glx_burst u_burst (
      .clock  (clock),
      .reset  (reset),
      .load   (accept),
      .burst  (burst),
      .ready  (ready),
      .rsp_ch (rsp_ch)
   );

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for graph_language_lexer_core
// Streams source bytes into the lexer, runs an in-bench lexer on each taken
// request and compares every response, field by field, with the oldest
// predicted token. Both channels idle at random, and the response side
// holds off once for a long stretch so that the request side backs up.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_BYTES = 100;
   localparam int STALL_LIMIT  = 2000;
   localparam int TAIL_CYCLES  = 20;

   typedef struct packed {
      logic [7:0] ch;
      logic       eoi;
   } src_byte_type;

   typedef struct packed {
      logic [4:0] kind;
      logic [7:0] value;
      logic       last;
   } token_type;

   typedef enum logic [3:0] {
      SCAN_IDLE, SCAN_SLASH, SCAN_LINE, SCAN_BLOCK, SCAN_BLOCK_STAR,
      SCAN_MINUS, SCAN_STRING, SCAN_ESCAPE, SCAN_WORD
   } scan_state_type;

   logic clock;
   logic reset;

   glx_req_if req_ch ();
   glx_rsp_if rsp_ch ();

   graph_language_lexer_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #4 clock = ~clock;

   // source text still to be sent, and tokens still to arrive
   src_byte_type   source_text[$];
   token_type      pending_tokens[$];
   token_type      step_tokens[$];
   int             total_bytes;

   // in-bench lexer state
   scan_state_type lex_mode;
   logic [7:0]     held_chars[glx_pkg::HOLD_LIMIT];
   int             held_n;
   bit             spilling;

   string          keywords[glx_pkg::KW_COUNT] = '{"strict", "digraph", "graph", "node",
                                                   "edge", "subgraph"};

   int             n_taken;
   int             n_tokens;
   int             n_bad;
   int             kind_seen[32];

   // ------------------------------------------------------------------------
   // lexer prediction
   // ------------------------------------------------------------------------
   function automatic bit is_word_char(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
             (b >= "0" && b <= "9") || b == "_" || b == ".";
   endfunction

   function automatic bit is_blank(logic [7:0] b);
      return b == " " || (b >= 8'd9 && b <= 8'd13);
   endfunction

   task put_tok(input logic [4:0] kind, input logic [7:0] value);
      token_type t;
      t.kind  = kind;
      t.value = (kind == glx_pkg::KIND_VALUE) ? value : 8'h00;
      t.last  = 1'b0;
      step_tokens.push_back(t);
   endtask

   task spill_held();
      for (int i = 0; i < held_n; i++) put_tok(glx_pkg::KIND_VALUE, held_chars[i]);
      held_n = 0;
   endtask

   task close_word();
      bit found;
      bit same;
      found = 1'b0;
      if (!spilling) begin
         for (int k = 0; k < glx_pkg::KW_COUNT; k++) begin
            same = (held_n == keywords[k].len());
            for (int i = 0; i < held_n && same; i++)
               if (held_chars[i] != keywords[k][i]) same = 1'b0;
            if (same && !found) begin
               found = 1'b1;
               put_tok(glx_pkg::KIND_KW_BASE + 5'(k), 8'h00);
            end
         end
         if (!found) spill_held();
      end
      if (!found) put_tok(glx_pkg::KIND_IDEND, 8'h00);
      held_n   = 0;
      spilling = 1'b0;
   endtask

   task scan_fresh(input logic [7:0] b);
      lex_mode = SCAN_IDLE;
      if (is_blank(b)) begin
      end else if (b == "/") begin
         lex_mode = SCAN_SLASH;
      end else if (b == "-") begin
         lex_mode = SCAN_MINUS;
      end else if (b == "\"") begin
         lex_mode = SCAN_STRING;
      end else if (is_word_char(b)) begin
         held_chars[0] = b;
         held_n        = 1;
         spilling      = 1'b0;
         lex_mode      = SCAN_WORD;
      end else begin
         case (b)
            "{": put_tok(glx_pkg::KIND_LBRACE, 8'h00);
            "}": put_tok(glx_pkg::KIND_RBRACE, 8'h00);
            ";": put_tok(glx_pkg::KIND_SEMI, 8'h00);
            "=": put_tok(glx_pkg::KIND_EQUAL, 8'h00);
            "[": put_tok(glx_pkg::KIND_LBRACKET, 8'h00);
            "]": put_tok(glx_pkg::KIND_RBRACKET, 8'h00);
            ",": put_tok(glx_pkg::KIND_COMMA, 8'h00);
            ":": put_tok(glx_pkg::KIND_COLON, 8'h00);
            "(": put_tok(glx_pkg::KIND_LPAREN, 8'h00);
            ")": put_tok(glx_pkg::KIND_RPAREN, 8'h00);
            "@": put_tok(glx_pkg::KIND_AT, 8'h00);
            default: put_tok(glx_pkg::KIND_ERROR, 8'h00);
         endcase
      end
   endtask

   task lex_byte(input logic [7:0] b, input logic eoi);
      step_tokens.delete();
      if (eoi) begin
         if (lex_mode == SCAN_IDLE) begin
            put_tok(glx_pkg::KIND_END, 8'h00);
         end else if (lex_mode == SCAN_WORD) begin
            close_word();
            put_tok(glx_pkg::KIND_END, 8'h00);
         end else begin
            put_tok(glx_pkg::KIND_ERROR, 8'h00);
         end
         lex_mode = SCAN_IDLE;
         held_n   = 0;
         spilling = 1'b0;
      end else begin
         case (lex_mode)
            SCAN_WORD: begin
               if (is_word_char(b)) begin
                  if (spilling) begin
                     put_tok(glx_pkg::KIND_VALUE, b);
                  end else if (held_n < glx_pkg::HOLD_LIMIT) begin
                     held_chars[held_n] = b;
                     held_n++;
                  end else begin
                     spill_held();
                     put_tok(glx_pkg::KIND_VALUE, b);
                     spilling = 1'b1;
                  end
               end else begin
                  close_word();
                  scan_fresh(b);
               end
            end
            SCAN_SLASH: begin
               if (b == "/") lex_mode = SCAN_LINE;
               else if (b == "*") lex_mode = SCAN_BLOCK;
               else begin
                  put_tok(glx_pkg::KIND_ERROR, 8'h00);
                  lex_mode = SCAN_IDLE;
               end
            end
            SCAN_LINE: if (b == "\n") lex_mode = SCAN_IDLE;
            SCAN_BLOCK: if (b == "*") lex_mode = SCAN_BLOCK_STAR;
            SCAN_BLOCK_STAR: begin
               if (b == "/") lex_mode = SCAN_IDLE;
               else if (b != "*") lex_mode = SCAN_BLOCK;
            end
            SCAN_MINUS: begin
               if (b == ">") put_tok(glx_pkg::KIND_ARROW, 8'h00);
               else if (b == "-") put_tok(glx_pkg::KIND_MINUSMINUS, 8'h00);
               else put_tok(glx_pkg::KIND_ERROR, 8'h00);
               lex_mode = SCAN_IDLE;
            end
            SCAN_STRING: begin
               if (b == "\"") begin
                  put_tok(glx_pkg::KIND_IDEND, 8'h00);
                  lex_mode = SCAN_IDLE;
               end else if (b == "\\") begin
                  lex_mode = SCAN_ESCAPE;
               end else begin
                  put_tok(glx_pkg::KIND_VALUE, b);
               end
            end
            SCAN_ESCAPE: begin
               put_tok(glx_pkg::KIND_VALUE, b);
               lex_mode = SCAN_STRING;
            end
            default: scan_fresh(b);
         endcase
      end
      if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1'b1;
      foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
   endtask

   // ------------------------------------------------------------------------
   // source text generation
   // ------------------------------------------------------------------------
   task add_byte(input logic [7:0] b);
      source_text.push_back(src_byte_type'{ch: b, eoi: 1'b0});
   endtask

   task add_text(input string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endtask

   task add_eoi();
      source_text.push_back(src_byte_type'{ch: 8'($urandom_range(0, 255)), eoi: 1'b1});
   endtask

   function automatic logic [7:0] pick(string s);
      return s[$urandom_range(0, s.len() - 1)];
   endfunction

   task add_random_token();
      string word_chars;
      string punct_chars;
      string blank_chars;
      int    roll;
      int    len;
      word_chars  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_.";
      punct_chars = "{};=[],:()@";
      blank_chars = " \t\n\r\v\f";
      roll        = $urandom_range(0, 99);
      if (roll < 18) begin
         add_text(keywords[$urandom_range(0, glx_pkg::KW_COUNT - 1)]);
      end else if (roll < 34) begin
         len = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 6);
         repeat (len) add_byte(pick(word_chars));
      end else if (roll < 50) begin
         add_byte(pick(punct_chars));
      end else if (roll < 58) begin
         add_text($urandom_range(0, 1) ? "->" : "--");
      end else if (roll < 68) begin
         add_byte("\"");
         repeat ($urandom_range(0, 5)) begin
            if ($urandom_range(0, 3) == 0) begin
               add_byte("\\");
               add_byte(8'($urandom_range(0, 255)));
            end else begin
               add_byte(pick(word_chars));
            end
         end
         add_byte("\"");
      end else if (roll < 74) begin
         add_text("//");
         repeat ($urandom_range(0, 4)) add_byte(pick("ab */-\""));
         add_byte("\n");
      end else if (roll < 80) begin
         add_text("/*");
         repeat ($urandom_range(0, 4)) add_byte(pick("ab *\n-"));
         add_text($urandom_range(0, 1) ? "*/" : "**/");
      end else if (roll < 85) begin
         add_byte(pick(blank_chars));
      end else if (roll < 90) begin
         // stray byte, anything at all
         add_byte(8'($urandom_range(0, 255)));
      end else if (roll < 94) begin
         // slash or minus with a random follower
         add_byte($urandom_range(0, 1) ? "/" : "-");
         add_byte(8'($urandom_range(0, 255)));
      end else if (roll < 97) begin
         // end of text, usually cut into an open construct
         add_byte(pick("/-\""));
         if ($urandom_range(0, 1)) add_byte(pick("*/a"));
         add_eoi();
      end else begin
         add_eoi();
      end
      if ($urandom_range(0, 9) < 7) add_byte(pick(blank_chars));
   endtask

   // ------------------------------------------------------------------------
   // request driver
   // ------------------------------------------------------------------------
   int sent;

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         sent = 0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (source_text.size() > 0 &&
             !((sent < 90 || sent >= 130) && $urandom_range(0, 99) < 8)) begin
            req_ch.valid        <= 1'b1;
            req_ch.byte_in      <= source_text[0].ch;
            req_ch.end_of_input <= source_text[0].eoi;
            void'(source_text.pop_front());
            sent++;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // response acceptance: random stalls plus one long hold-off
   // ------------------------------------------------------------------------
   int rx_cycles;
   int hold_left;
   bit hold_done;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rx_cycles = 0;
         hold_left = 0;
         hold_done = 1'b0;
      end else begin
         rx_cycles++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!hold_done && rx_cycles >= 60) begin
            hold_done = 1'b1;
            hold_left = 60;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= (rx_cycles >= 150 && rx_cycles < 220) ||
                            ($urandom_range(0, 99) >= 8);
         end
      end
   end

   // ------------------------------------------------------------------------
   // monitor: predict on each taken request, check each taken response
   // ------------------------------------------------------------------------
   task report_bad(input string what, input token_type want, input token_type got);
      n_bad++;
      if (n_bad <= 10)
         $display("%0t: %s: expected kind %0d value %02h last %0b, %s %0d value %02h last %0b",
                  $realtime, what, want.kind, want.value, want.last,
                  "got kind", got.kind, got.value, got.last);
   endtask

   always @(posedge clock) begin
      token_type got;
      token_type want;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            lex_byte(req_ch.byte_in, req_ch.end_of_input);
            n_taken++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.kind  = rsp_ch.kind;
            got.value = rsp_ch.value_byte;
            got.last  = rsp_ch.last_of_run;
            n_tokens++;
            kind_seen[got.kind]++;
            if (pending_tokens.size() == 0) begin
               report_bad("unexpected token", '0, got);
            end else begin
               want = pending_tokens.pop_front();
               if (got.kind != want.kind) report_bad("kind mismatch", want, got);
               else if (got.value != want.value) report_bad("value mismatch", want, got);
               else if (got.last != want.last) report_bad("last mismatch", want, got);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // watchdog: no progress on either channel for too long
   // ------------------------------------------------------------------------
   int quiet_cycles;

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles = 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no transfer for %0d cycles, %0d tokens outstanding",
                  quiet_cycles, pending_tokens.size());
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles++;
      end
   end

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      int kinds_hit;
      clock               = 1'b0;
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.byte_in      = 8'h00;
      req_ch.end_of_input = 1'b0;
      rsp_ch.ready        = 1'b0;
      lex_mode            = SCAN_IDLE;
      held_n              = 0;
      spilling            = 1'b0;
      n_taken             = 0;
      n_tokens            = 0;
      n_bad               = 0;

      // directed: NUL and 0xFF strays, arrow, bad slash follower, "**/" close,
      // escaped quote in a string, a nine-byte spill, then end of text
      add_byte(8'h00);
      add_byte(8'hFF);
      add_text("->/x/***/\"\\\"\"subgraphX;");
      add_eoi();
      total_bytes = source_text.size();

      while (source_text.size() < total_bytes + RANDOM_BYTES) add_random_token();
      add_eoi();
      total_bytes = source_text.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (n_taken < total_bytes || pending_tokens.size() > 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      kinds_hit = 0;
      for (int k = 0; k <= glx_pkg::KIND_IDEND; k++) if (kind_seen[k] > 0) kinds_hit++;
      $display("lexed %0d source bytes into %0d tokens, %0d of %0d token kinds seen",
               n_taken, n_tokens, kinds_hit, glx_pkg::KIND_IDEND + 1);
      $display("%0d mismatches, %0d tokens left unmatched", n_bad, pending_tokens.size());

      if (n_bad == 0 && pending_tokens.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
